@@ hdl/bsc_pkg.sv @@
// Shared types and constants of the Baudot shift codec.
package bsc_pkg;

  // Operation codes of an input request
  typedef enum logic [1:0] {
    OP_LOAD_LETTERS = 2'd0,
    OP_LOAD_FIGURES = 2'd1,
    OP_ENCODE       = 2'd2,
    OP_DECODE       = 2'd3
  } op_e;

  // Kind of a result
  typedef enum logic {
    KIND_CODE = 1'b0,
    KIND_CHAR = 1'b1
  } kind_e;

  // Register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_LETTERS_SHIFT = 2'd0,
    REG_FIGURES_SHIFT = 2'd1,
    REG_UNKNOWN_CODE  = 2'd2,
    REG_NONE          = 2'd3
  } reg_idx_e;

  localparam logic [4:0] LettersShiftReset = 5'b11011;
  localparam logic [4:0] FiguresShiftReset = 5'b11111;
  localparam logic [4:0] UnknownCodeReset  = 5'b00000;

  typedef struct packed {
    op_e        op;
    logic       message_start;
    logic [7:0] char_in;
    logic [4:0] code_in;
  } in_item_t;

  typedef struct packed {
    kind_e      kind;
    logic [4:0] code_out;
    logic [7:0] char_out;
    logic       last;
  } out_item_t;

  // Write into the character-to-code table
  typedef struct packed {
    logic       en;
    logic       figures;
    logic [7:0] addr;
    logic [4:0] letters_code;
    logic [4:0] figures_code;
  } c2c_wr_t;

  // Write into the code-to-character table
  typedef struct packed {
    logic       en;
    logic       figures;
    logic [4:0] addr;
    logic [7:0] char_val;
  } k2c_wr_t;

endpackage

@@ hdl/baudot_shift_codec_unit.sv @@
// Top level of the Baudot shift codec: request stage, case logic and registers.
//
// Usage: requests enter on in_valid_i/in_data_i and are taken at an edge where
// in_valid_i is high and in_stall_o is low. Load requests fill the letters and
// figures tables and give no result. Encode requests give one result, or two
// (shift code, then character code) when the character lives only in the other
// case. Decode requests give one character or nothing. Results leave on
// out_valid_o/out_data_o and are taken when out_stall_i is low; last marks the
// final result of a request.
// A request is held in the request stage and its results are registered in the
// result buffer before they are offered. Throughput: one request per cycle while
// each gives at most one result and out_stall_i is low; a request with two
// results fills the two-entry buffer, drained by the single output port.
// Reset clears every table written flag at once (no clearing pass), sets both
// directions to letters case and the registers to 27, 31 and 0.
// When the receiver stalls, results wait in the buffer; the request stage holds
// its request and raises in_stall_o while its results do not fit the buffer.
// Registers sit at byte addresses 0, 4 and 8 of the APB port.
module baudot_shift_codec_unit
  import bsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [4:0] letters_shift_q;
  logic [4:0] figures_shift_q;
  logic [4:0] unknown_code_q;
  reg_idx_e   reg_idx;

  logic       s1_valid_q;
  in_item_t   s1_q;
  logic       accept;
  logic       fire;

  logic       enc_fig_q, enc_fig_d;
  logic       dec_fig_q, dec_fig_d;

  logic       c_lv, c_fv;
  logic [4:0] c_lcode, c_fcode;
  logic       k_lv, k_fv;
  logic [7:0] k_lch, k_fch;

  c2c_wr_t    c2c_wr;
  k2c_wr_t    k2c_wr;
  logic [1:0] push_cnt;
  logic [1:0] space;
  out_item_t  push0, push1;

  logic       enc_cur;
  logic       dec_cur;
  logic       cur_valid, oth_valid;
  logic [4:0] cur_code, oth_code;
  logic       load_fig;
  logic       load_present;

  // Configuration registers
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      letters_shift_q <= LettersShiftReset;
      figures_shift_q <= FiguresShiftReset;
      unknown_code_q  <= UnknownCodeReset;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_LETTERS_SHIFT: letters_shift_q <= pwdata[4:0];
        REG_FIGURES_SHIFT: figures_shift_q <= pwdata[4:0];
        REG_UNKNOWN_CODE:  unknown_code_q  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LETTERS_SHIFT: prdata = {27'd0, letters_shift_q};
      REG_FIGURES_SHIFT: prdata = {27'd0, figures_shift_q};
      REG_UNKNOWN_CODE:  prdata = {27'd0, unknown_code_q};
      default:           prdata = 32'd0;
    endcase
  end

  // Request stage
  assign fire       = s1_valid_q && (push_cnt <= space);
  assign in_stall_o = s1_valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= in_data_i;
    end
  end

  // Tables
  bsc_char_table u_char_table (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .rd_en_i         (accept),
    .rd_addr_i       (in_data_i.char_in),
    .wr_i            (c2c_wr),
    .letters_valid_o (c_lv),
    .figures_valid_o (c_fv),
    .letters_code_o  (c_lcode),
    .figures_code_o  (c_fcode)
  );

  bsc_code_table u_code_table (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .lookup_addr_i   (s1_q.code_in),
    .wr_i            (k2c_wr),
    .letters_valid_o (k_lv),
    .figures_valid_o (k_fv),
    .letters_char_o  (k_lch),
    .figures_char_o  (k_fch)
  );

  // Case after an optional message start
  assign enc_cur   = s1_q.message_start ? 1'b0 : enc_fig_q;
  assign dec_cur   = s1_q.message_start ? 1'b0 : dec_fig_q;
  assign cur_valid = enc_cur ? c_fv : c_lv;
  assign oth_valid = enc_cur ? c_lv : c_fv;
  assign cur_code  = enc_cur ? c_fcode : c_lcode;
  assign oth_code  = enc_cur ? c_lcode : c_fcode;
  assign load_fig  = (s1_q.op == OP_LOAD_FIGURES);
  assign load_present = load_fig ? c_fv : c_lv;

  // Work out results, table writes and next case
  always_comb begin
    push_cnt  = 2'd0;
    push0     = '{kind: KIND_CODE, code_out: 5'd0, char_out: 8'd0, last: 1'b1};
    push1     = '{kind: KIND_CODE, code_out: 5'd0, char_out: 8'd0, last: 1'b1};
    enc_fig_d = enc_fig_q;
    dec_fig_d = dec_fig_q;

    c2c_wr.en           = 1'b0;
    c2c_wr.figures      = load_fig;
    c2c_wr.addr         = s1_q.char_in;
    c2c_wr.letters_code = load_fig ? c_lcode : s1_q.code_in;
    c2c_wr.figures_code = load_fig ? s1_q.code_in : c_fcode;
    k2c_wr.en           = 1'b0;
    k2c_wr.figures      = load_fig;
    k2c_wr.addr         = s1_q.code_in;
    k2c_wr.char_val     = s1_q.char_in;

    case (s1_q.op)
      OP_LOAD_LETTERS, OP_LOAD_FIGURES: begin
        c2c_wr.en = fire && !load_present;
        k2c_wr.en = fire && !load_present && !(load_fig ? k_fv : k_lv);
      end
      OP_ENCODE: begin
        enc_fig_d = enc_cur;
        if (cur_valid) begin
          push_cnt       = 2'd1;
          push0.code_out = cur_code;
        end else if (oth_valid) begin
          push_cnt       = 2'd2;
          push0.code_out = enc_cur ? letters_shift_q : figures_shift_q;
          push0.last     = 1'b0;
          push1.code_out = oth_code;
          enc_fig_d      = !enc_cur;
        end else begin
          push_cnt       = 2'd1;
          push0.code_out = unknown_code_q;
        end
      end
      OP_DECODE: begin
        dec_fig_d = dec_cur;
        if (s1_q.code_in == letters_shift_q) begin
          dec_fig_d = 1'b0;
        end else if (s1_q.code_in == figures_shift_q) begin
          dec_fig_d = 1'b1;
        end else if (dec_cur ? k_fv : k_lv) begin
          push_cnt       = 2'd1;
          push0.kind     = KIND_CHAR;
          push0.char_out = dec_cur ? k_fch : k_lch;
        end
      end
      default: ;
    endcase
  end

  // Hold the case of each direction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_fig_q <= 1'b0;
      dec_fig_q <= 1'b0;
    end else if (fire) begin
      enc_fig_q <= enc_fig_d;
      dec_fig_q <= dec_fig_d;
    end
  end

  // Result buffer
  bsc_out_queue u_out_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_cnt_i  (fire ? push_cnt : 2'd0),
    .push0_i     (push0),
    .push1_i     (push1),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

@@ hdl/bsc_char_table.sv @@
// Character-to-code table: 256-entry memory of both cases' codes with per-entry written flags.
module bsc_char_table
  import bsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rd_en_i,
  input  logic [7:0] rd_addr_i,
  input  c2c_wr_t    wr_i,
  output logic       letters_valid_o,
  output logic       figures_valid_o,
  output logic [4:0] letters_code_o,
  output logic [4:0] figures_code_o
);

  // Entry layout: letters valid, letters code, figures valid, figures code
  logic [11:0]  mem [256];
  logic [11:0]  rdata_q;
  logic         rwritten_q;
  logic [255:0] written_q;
  logic [11:0]  rdata;
  logic [11:0]  wdata;
  logic         bypass;

  // An entry never written reads as zero
  assign rdata           = rwritten_q ? rdata_q : 12'd0;
  assign letters_valid_o = rdata[11];
  assign letters_code_o  = rdata[10:6];
  assign figures_valid_o = rdata[5];
  assign figures_code_o  = rdata[4:0];

  // Keep the other case's half, set the valid bit of the loaded case
  assign wdata  = {wr_i.figures ? letters_valid_o : 1'b1, wr_i.letters_code,
                   wr_i.figures ? 1'b1 : figures_valid_o, wr_i.figures_code};
  assign bypass = wr_i.en && (wr_i.addr == rd_addr_i);

  // Write the entry
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wdata;
    end
  end

  // Read at request accept, bypass a write to the same entry
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (bypass) begin
        rdata_q <= wdata;
      end else begin
        rdata_q <= mem[rd_addr_i];
      end
    end
  end

  // Mark written entries, clear all marks at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q  <= '0;
      rwritten_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        written_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rwritten_q <= bypass || written_q[rd_addr_i];
      end
    end
  end

endmodule

@@ hdl/bsc_code_table.sv @@
// Code-to-character table: 32 entries per case with valid flops.
module bsc_code_table
  import bsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [4:0] lookup_addr_i,
  input  k2c_wr_t    wr_i,
  output logic       letters_valid_o,
  output logic       figures_valid_o,
  output logic [7:0] letters_char_o,
  output logic [7:0] figures_char_o
);

  logic [7:0]  lch_q [32];
  logic [7:0]  fch_q [32];
  logic [31:0] lv_q;
  logic [31:0] fv_q;

  // Store the character of a new code
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      if (wr_i.figures) begin
        fch_q[wr_i.addr] <= wr_i.char_val;
      end else begin
        lch_q[wr_i.addr] <= wr_i.char_val;
      end
    end
  end

  // Set valid bits, clear all at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lv_q <= '0;
      fv_q <= '0;
    end else if (wr_i.en) begin
      if (wr_i.figures) begin
        fv_q[wr_i.addr] <= 1'b1;
      end else begin
        lv_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  assign letters_valid_o = lv_q[lookup_addr_i];
  assign figures_valid_o = fv_q[lookup_addr_i];
  assign letters_char_o  = lch_q[lookup_addr_i];
  assign figures_char_o  = fch_q[lookup_addr_i];

endmodule

@@ hdl/bsc_out_queue.sv @@
// Two-entry result buffer that takes up to two results per cycle.
module bsc_out_queue
  import bsc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic [1:0] push_cnt_i,
  input  out_item_t push0_i,
  input  out_item_t push1_i,
  output logic [1:0] space_o,
  output logic      out_valid_o,
  output out_item_t out_data_o,
  input  logic      out_stall_i
);

  out_item_t  ent_q [2];
  out_item_t  ent_d [2];
  logic [1:0] cnt_q;
  logic [1:0] cnt_d;
  logic [1:0] rem;
  logic       pop;

  assign pop     = (cnt_q != 2'd0) && !out_stall_i;
  assign rem     = cnt_q - {1'b0, pop};
  assign space_o = 2'd2 - rem;

  // Drop the head on a take, then append new results
  always_comb begin
    ent_d[0] = ent_q[0];
    ent_d[1] = ent_q[1];
    if (pop) begin
      ent_d[0] = ent_q[1];
    end
    if (push_cnt_i != 2'd0) begin
      ent_d[rem[0]] = push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      ent_d[1] = push1_i;
    end
    cnt_d = rem + push_cnt_i;
  end

  always_ff @(posedge clk_i) begin
    ent_q[0] <= ent_d[0];
    ent_q[1] <= ent_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = ent_q[0];

endmodule
